FILE: sv/nsqc_pkg.sv
// package for the nested scissor quad clipper
// holds opcodes, state encoding and default sizes; no dependencies
`default_nettype none
package nsqc_pkg;
	localparam int DefStackDepth = 16;
	localparam int DefMaxQuads = 16384;

	typedef enum logic [1:0] {
		OP_DRAW  = 2'd0,
		OP_PUSH  = 2'd1,
		OP_POP   = 2'd2,
		OP_BEGIN = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DIV,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

FILE: sv/nested_scissor_quad_clipper_unit.sv
// nested scissor quad clipper: top level
// uses nsqc_pkg; holds the scissor stack memory and a shared serial divider
//
// Commands come in on the in channel (valid/ready), one item at a time.
// Push stores the rectangle intersected with the top of the stack, pop drops
// the top entry, begin frame empties the stack and the quad counter.
// A draw reads the top scissor from the stack memory (a registered read),
// tests and clamps, and for each clipped edge of a textured draw runs the
// shared restoring divider over 48 quotient bits (one bit a cycle).
// A push, pop or begin frame steps through read and eval; a kept draw steps
// through read, eval, div (stack not empty) and out, plus any out channel
// stall; each clipped textured edge adds a divider run (up to four per draw).
// At most one result per draw leaves on the out channel, held in an output
// register; while the receiver stalls the block holds and accepts nothing.
// Reset empties the stack and clears the quad counter; stack entries above
// the count are never read, so the memory needs no clearing.
`default_nettype none
module nested_scissor_quad_clipper_unit #(
	parameter int STACK_DEPTH = nsqc_pkg::DefStackDepth,
	parameter int MAX_QUADS = nsqc_pkg::DefMaxQuads
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         operation,
	input  wire logic signed [15:0] left,
	input  wire logic signed [15:0] top,
	input  wire logic signed [15:0] right,
	input  wire logic signed [15:0] bottom,
	input  wire logic [16:0]        tex_u0,
	input  wire logic [16:0]        tex_v0,
	input  wire logic [16:0]        tex_u1,
	input  wire logic [16:0]        tex_v1,
	input  wire logic [31:0]        rgba,
	input  wire logic               textured,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      out_left,
	output logic signed [15:0]      out_top,
	output logic signed [15:0]      out_right,
	output logic signed [15:0]      out_bottom,
	output logic [16:0]             out_u0,
	output logic [16:0]             out_v0,
	output logic [16:0]             out_u1,
	output logic [16:0]             out_v1,
	output logic [31:0]             out_rgba,
	output logic [15:0]             base_vertex
);
	import nsqc_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int QW = $clog2(MAX_QUADS + 1);
	localparam int NW = 48;

	state_t state_q, state_d;

	// latched item
	op_t                op_q;
	logic signed [15:0] x0_q, y0_q, x1_q, y1_q;
	logic [16:0]        u0_q, v0_q, u1_q, v1_q;
	logic [31:0]        rgba_q;
	logic               tex_q;

	logic [CW-1:0] cnt_q;
	logic [QW-1:0] quads_q;

	// stack memory
	logic [63:0]   mem [STACK_DEPTH];
	logic [63:0]   rd_s1;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0]   wdata;

	// scissor fields and working result
	logic signed [15:0] cx0, cy0, cx1, cy1;
	logic signed [15:0] ox0_q, oy0_q, ox1_q, oy1_q;
	logic [16:0]        nu0_q, nv0_q, nu1_q, nv1_q;
	logic [3:0]         todo_q;
	logic [1:0]         edge_q;

	// divider
	logic [NW-1:0] num_q, quo_q;
	logic [17:0]   den_q;
	logic [18:0]   rem_q;
	logic [5:0]    dcnt_q;
	logic          dbusy_q;

	assign cx0 = rd_s1[63:48];
	assign cy0 = rd_s1[47:32];
	assign cx1 = rd_s1[31:16];
	assign cy1 = rd_s1[15:0];

	assign in_ready = (state_q == ST_IDLE);
	assign raddr = AW'(cnt_q - CW'(1));

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_READ;
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: begin
				if (op_q != OP_DRAW) state_d = ST_IDLE;
				else if (32'(quads_q) >= MAX_QUADS) state_d = ST_IDLE;
				else if (cnt_q == '0) state_d = ST_OUT;
				else if (x1_q < cx0 || x0_q > cx1 || y1_q < cy0 || y0_q > cy1)
					state_d = ST_IDLE;
				else state_d = ST_DIV;
			end
			ST_DIV: if (todo_q == '0 && !dbusy_q) state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// push write
	always_comb begin
		we = 1'b0;
		waddr = AW'(cnt_q);
		wdata = {x0_q, y0_q, x1_q, y1_q};
		if (state_q == ST_EVAL && op_q == OP_PUSH && 32'(cnt_q) < STACK_DEPTH) begin
			we = 1'b1;
			if (cnt_q != '0) begin
				wdata = {(x0_q > cx0) ? x0_q : cx0, (y0_q > cy0) ? y0_q : cy0,
					(x1_q < cx1) ? x1_q : cx1, (y1_q < cy1) ? y1_q : cy1};
			end
		end
	end

	// divider setup values for the next pending edge
	logic [1:0]         pick;
	logic signed [16:0] sn, sd;
	logic [16:0]        ua, ub;
	always_comb begin
		pick = 2'd0;
		if (todo_q[0]) pick = 2'd0;
		else if (todo_q[1]) pick = 2'd1;
		else if (todo_q[2]) pick = 2'd2;
		else pick = 2'd3;
		case (pick)
			2'd0: begin sn = 17'(cx0) - 17'(x0_q); sd = 17'(x1_q) - 17'(x0_q);
				ua = u0_q; ub = u1_q; end
			2'd1: begin sn = 17'(cx1) - 17'(x0_q); sd = 17'(x1_q) - 17'(x0_q);
				ua = u0_q; ub = u1_q; end
			2'd2: begin sn = 17'(cy0) - 17'(y0_q); sd = 17'(y1_q) - 17'(y0_q);
				ua = v0_q; ub = v1_q; end
			default: begin sn = 17'(cy1) - 17'(y0_q); sd = 17'(y1_q) - 17'(y0_q);
				ua = v0_q; ub = v1_q; end
		endcase
	end

	logic [18:0] trial;
	logic [16:0] qres;
	assign trial = {rem_q[17:0], num_q[NW-1]} - {1'b0, den_q};
	assign qres = quo_q[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			quads_q <= '0;
			dbusy_q <= 1'b0;
			todo_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_EVAL: begin
					case (op_q)
						OP_BEGIN: begin cnt_q <= '0; quads_q <= '0; end
						OP_POP: if (cnt_q != '0) cnt_q <= cnt_q - CW'(1);
						OP_PUSH: if (32'(cnt_q) < STACK_DEPTH) cnt_q <= cnt_q + CW'(1);
						default: begin
							if (cnt_q != '0 && tex_q) begin
								todo_q <= {y1_q > cy1, y0_q < cy0, x1_q > cx1, x0_q < cx0};
							end else begin
								todo_q <= '0;
							end
						end
					endcase
				end
				ST_DIV: begin
					if (dbusy_q) begin
						if (dcnt_q == 6'(NW - 1)) dbusy_q <= 1'b0;
					end else if (todo_q != '0) begin
						todo_q[pick] <= 1'b0;
						if (sd > 0) dbusy_q <= 1'b1;
					end
				end
				ST_OUT: if (out_ready) quads_q <= quads_q + QW'(1);
				default: ;
			endcase
		end
	end

	// datapath registers
	logic [NW-1:0] prod_num;
	assign prod_num = NW'(ua) * NW'(17'(sd - sn)) + NW'(ub) * NW'(17'(sn))
		+ NW'(17'(sd) >> 1);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) begin
				op_q <= op_t'(operation);
				x0_q <= left; y0_q <= top; x1_q <= right; y1_q <= bottom;
				u0_q <= tex_u0; v0_q <= tex_v0; u1_q <= tex_u1; v1_q <= tex_v1;
				rgba_q <= rgba; tex_q <= textured;
			end
			ST_EVAL: begin
				// clamp to the top scissor when the stack is not empty
				ox0_q <= (cnt_q != '0 && x0_q < cx0) ? cx0 : x0_q;
				ox1_q <= (cnt_q != '0 && x1_q > cx1) ? cx1 : x1_q;
				oy0_q <= (cnt_q != '0 && y0_q < cy0) ? cy0 : y0_q;
				oy1_q <= (cnt_q != '0 && y1_q > cy1) ? cy1 : y1_q;
				nu0_q <= u0_q; nv0_q <= v0_q; nu1_q <= u1_q; nv1_q <= v1_q;
			end
			ST_DIV: begin
				if (dbusy_q) begin
					// one quotient bit a cycle
					if (!trial[18]) begin
						rem_q <= trial;
						quo_q <= {quo_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[17:0], num_q[NW-1]};
						quo_q <= {quo_q[NW-2:0], 1'b0};
					end
					num_q <= {num_q[NW-2:0], 1'b0};
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'(NW - 1)) begin
						case (edge_q)
							2'd0: nu0_q <= (!trial[18]) ? {qres[15:0], 1'b1} : {qres[15:0], 1'b0};
							2'd1: nu1_q <= (!trial[18]) ? {qres[15:0], 1'b1} : {qres[15:0], 1'b0};
							2'd2: nv0_q <= (!trial[18]) ? {qres[15:0], 1'b1} : {qres[15:0], 1'b0};
							default: nv1_q <= (!trial[18]) ? {qres[15:0], 1'b1} : {qres[15:0], 1'b0};
						endcase
					end
				end else if (todo_q != '0) begin
					edge_q <= pick;
					num_q <= prod_num;
					den_q <= 18'(sd[15:0]) | {1'b0, sd[16], 16'd0};
					rem_q <= '0;
					quo_q <= '0;
					dcnt_q <= '0;
					if (!(sd > 0)) begin
						case (pick)
							2'd0: nu0_q <= ua;
							2'd1: nu1_q <= ua;
							2'd2: nv0_q <= ua;
							default: nv1_q <= ua;
						endcase
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid = (state_q == ST_OUT);
	assign out_left = ox0_q;
	assign out_top = oy0_q;
	assign out_right = ox1_q;
	assign out_bottom = oy1_q;
	assign out_u0 = nu0_q;
	assign out_v0 = nv0_q;
	assign out_u1 = nu1_q;
	assign out_v1 = nv1_q;
	assign out_rgba = rgba_q;
	assign base_vertex = 16'({quads_q, 2'b00});
endmodule
`default_nettype wire

FILE: test/tb_nested_scissor_quad_clipper_unit.sv
// testbench for the nested scissor quad clipper unit
// depends on nsqc_pkg and nested_scissor_quad_clipper_unit; self-checking, no files
`default_nettype none
module tb_nested_scissor_quad_clipper_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import nsqc_pkg::*;

	localparam int DEPTH = DefStackDepth;
	localparam int QUAD_LIMIT = DefMaxQuads;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic signed [15:0] x0, y0, x1, y1;
		logic [16:0] u0, v0, u1, v1;
		logic [31:0] rgba;
		logic [15:0] vtx;
	} quad_t;

	typedef struct packed {
		logic signed [15:0] x0, y0, x1, y1;
	} box_t;

	// clipper predictor plus queue of expected quads
	class quad_board;
		box_t clip_stack [DEPTH];
		int depth_used;
		int quads_emitted;
		quad_t pending [$];
		int errors;
		int matched;

		function logic [16:0] mix_uv(logic [16:0] ua, logic [16:0] ub, int n, int d);
			longint num;
			if (d <= 0)
				return ua;
			num = longint'(ua) * (d - n) + longint'(ub) * n + d / 2;
			return 17'(num / d);
		endfunction

		function void clear();
			depth_used = 0;
			quads_emitted = 0;
		endfunction

		function void note_item(op_t op, box_t b, logic [16:0] u0, logic [16:0] v0,
				logic [16:0] u1, logic [16:0] v1, logic [31:0] col, logic tex);
			box_t t;
			quad_t q;
			int dx, dy;
			case (op)
				OP_BEGIN: begin
					clear();
				end
				OP_POP: begin
					if (depth_used > 0)
						depth_used--;
				end
				OP_PUSH: begin
					if (depth_used < DEPTH) begin
						if (depth_used > 0) begin
							t = clip_stack[depth_used - 1];
							if (t.x0 > b.x0) b.x0 = t.x0;
							if (t.y0 > b.y0) b.y0 = t.y0;
							if (t.x1 < b.x1) b.x1 = t.x1;
							if (t.y1 < b.y1) b.y1 = t.y1;
						end
						clip_stack[depth_used] = b;
						depth_used++;
					end
				end
				default: begin
					if (quads_emitted >= QUAD_LIMIT)
						return;
					q = '{b.x0, b.y0, b.x1, b.y1, u0, v0, u1, v1, col, 16'(quads_emitted * 4)};
					if (depth_used > 0) begin
						t = clip_stack[depth_used - 1];
						if (b.x1 < t.x0 || b.x0 > t.x1 || b.y1 < t.y0 || b.y0 > t.y1)
							return;
						dx = int'(b.x1) - int'(b.x0);
						dy = int'(b.y1) - int'(b.y0);
						// both sides measure from the original min edge
						if (b.x0 < t.x0) begin
							if (tex) q.u0 = mix_uv(u0, u1, int'(t.x0) - int'(b.x0), dx);
							q.x0 = t.x0;
						end
						if (b.x1 > t.x1) begin
							if (tex) q.u1 = mix_uv(u0, u1, int'(t.x1) - int'(b.x0), dx);
							q.x1 = t.x1;
						end
						if (b.y0 < t.y0) begin
							if (tex) q.v0 = mix_uv(v0, v1, int'(t.y0) - int'(b.y0), dy);
							q.y0 = t.y0;
						end
						if (b.y1 > t.y1) begin
							if (tex) q.v1 = mix_uv(v0, v1, int'(t.y1) - int'(b.y0), dy);
							q.y1 = t.y1;
						end
					end
					pending = {pending, q};
					quads_emitted++;
				end
			endcase
		endfunction

		function void check_quad(quad_t got);
			quad_t exp_q;
			if (pending.size() == 0) begin
				$display("%0t: unexpected quad %h", $realtime, got);
				errors++;
				return;
			end
			exp_q = pending.pop_front();
			if (got.x0 !== exp_q.x0) report("out_left", exp_q.x0, got.x0);
			if (got.y0 !== exp_q.y0) report("out_top", exp_q.y0, got.y0);
			if (got.x1 !== exp_q.x1) report("out_right", exp_q.x1, got.x1);
			if (got.y1 !== exp_q.y1) report("out_bottom", exp_q.y1, got.y1);
			if (got.u0 !== exp_q.u0) report("out_u0", exp_q.u0, got.u0);
			if (got.v0 !== exp_q.v0) report("out_v0", exp_q.v0, got.v0);
			if (got.u1 !== exp_q.u1) report("out_u1", exp_q.u1, got.u1);
			if (got.v1 !== exp_q.v1) report("out_v1", exp_q.v1, got.v1);
			if (got.rgba !== exp_q.rgba) report("out_rgba", exp_q.rgba, got.rgba);
			if (got.vtx !== exp_q.vtx) report("base_vertex", exp_q.vtx, got.vtx);
			matched++;
		endfunction

		function void report(string field, logic [31:0] e, logic [31:0] a);
			$display("%0t: %s expected %h got %h", $realtime, field, e, a);
			errors++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] operation = '0;
	logic signed [15:0] left = '0, top = '0, right = '0, bottom = '0;
	logic [16:0] tex_u0 = '0, tex_v0 = '0, tex_u1 = '0, tex_v1 = '0;
	logic [31:0] rgba = '0;
	logic textured = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] out_left, out_top, out_right, out_bottom;
	logic [16:0] out_u0, out_v0, out_u1, out_v1;
	logic [31:0] out_rgba;
	logic [15:0] base_vertex;

	quad_board board;
	bit stim_done = 1'b0;
	int cycles = 0;
	int n_draw = 0, n_push = 0, n_pop = 0, n_begin = 0;

	nested_scissor_quad_clipper_unit u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, a few long ones, often none
	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// drive one item and wait for the handshake; valid stays up into a
	// back to back item and drops only over a gap
	task automatic send(op_t op, box_t b, logic [16:0] u0, logic [16:0] v0,
			logic [16:0] u1, logic [16:0] v1, logic [31:0] col, logic tex);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		left <= b.x0; top <= b.y0; right <= b.x1; bottom <= b.y1;
		tex_u0 <= u0; tex_v0 <= v0; tex_u1 <= u1; tex_v1 <= v1;
		rgba <= col; textured <= tex;
		do @(posedge clk); while (!in_ready);
		board.note_item(op, b, u0, v0, u1, v1, col, tex);
		case (op)
			OP_DRAW: n_draw++;
			OP_PUSH: n_push++;
			OP_POP: n_pop++;
			default: n_begin++;
		endcase
	endtask

	function logic [16:0] rand_uv();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 17'd0;
		if (r == 1) return 17'd65536;
		return 17'($urandom_range(0, 65536));
	endfunction

	function box_t rand_box(bit wide);
		box_t b;
		int cx, cy;
		if (wide)
			return box_t'({16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)});
		cx = $urandom_range(0, 4000) - 2000;
		cy = $urandom_range(0, 4000) - 2000;
		b.x0 = 16'(cx - $urandom_range(0, 1500));
		b.y0 = 16'(cy - $urandom_range(0, 1500));
		b.x1 = 16'(cx + $urandom_range(0, 1500));
		b.y1 = 16'(cy + $urandom_range(0, 1500));
		return b;
	endfunction

	task automatic rand_draw();
		send(OP_DRAW, rand_box($urandom_range(0, 9) == 0), rand_uv(), rand_uv(),
			rand_uv(), rand_uv(), $urandom, $urandom_range(0, 4) != 0);
	endtask

	// receiver with random stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_quad('{out_left, out_top, out_right, out_bottom,
					out_u0, out_v0, out_u1, out_v1, out_rgba, base_vertex});
			out_ready <= ($urandom_range(0, 99) < 8) ? 1'b0 :
				($urandom_range(0, 99) < 70);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int k;
		int waited;
		board = new();
		board.clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty stack, extremes, pop on empty, nesting, full stack
		send(OP_POP, '0, 0, 0, 0, 0, 0, 0);
		send(OP_DRAW, '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767},
			0, 0, 17'd65536, 17'd65536, 32'hffffffff, 1);
		send(OP_PUSH, '{-16'sd160, -16'sd160, 16'sd160, 16'sd160}, 0, 0, 0, 0, 0, 0);
		send(OP_DRAW, '{-16'sd320, -16'sd320, 16'sd320, 16'sd320},
			0, 0, 17'd65536, 17'd65536, 32'h12345678, 1);
		send(OP_DRAW, '{-16'sd320, -16'sd320, 16'sd320, 16'sd320},
			17'd65536, 17'd65536, 0, 0, 32'h0, 0);
		send(OP_DRAW, '{16'sd200, 16'sd0, 16'sd300, 16'sd10}, 1, 2, 3, 4, 32'h5, 1);
		send(OP_PUSH, '{-16'sd32768, 16'sd0, 16'sd32767, 16'sd32767},
			0, 0, 0, 0, 0, 0);
		send(OP_DRAW, '{-16'sd100, -16'sd100, 16'sd100, 16'sd100},
			17'd100, 17'd70000 & 17'h1ffff, 17'd900, 17'd3, 32'haaaa5555, 1);
		// inverted scissor and inverted draw
		send(OP_PUSH, '{16'sd50, 16'sd50, -16'sd50, -16'sd50}, 0, 0, 0, 0, 0, 0);
		send(OP_DRAW, '{16'sd60, 16'sd60, -16'sd60, -16'sd60},
			17'd10, 17'd20, 17'd30, 17'd40, 32'h1, 1);
		for (k = 0; k < DEPTH + 2; k++)
			send(OP_PUSH, rand_box(0), 0, 0, 0, 0, 0, 0);
		send(OP_DRAW, '{-16'sd5, -16'sd5, 16'sd5, 16'sd5},
			17'd0, 17'd0, 17'd65536, 17'd65536, 32'h7, 1);
		send(OP_BEGIN, '0, 0, 0, 0, 0, 0, 0);

		// random: draws, nested pushes, pops and frame starts, with noise in unused fields
		k = 0;
		while (k < 400) begin
			int r;
			r = $urandom_range(0, 99);
			if (r < 55) rand_draw();
			else if (r < 75) send(OP_PUSH, rand_box($urandom_range(0, 7) == 0),
				rand_uv(), rand_uv(), rand_uv(), rand_uv(), $urandom, $urandom_range(0, 1));
			else if (r < 94) send(OP_POP, rand_box(1), rand_uv(), rand_uv(), rand_uv(),
				rand_uv(), $urandom, $urandom_range(0, 1));
			else send(OP_BEGIN, rand_box(1), rand_uv(), rand_uv(), rand_uv(), rand_uv(),
				$urandom, $urandom_range(0, 1));
			k++;
		end
		in_valid <= 1'b0;

		waited = 0;
		while (board.pending.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);
		$display("covered %0d draws, %0d pushes, %0d pops, %0d frame starts",
			n_draw, n_push, n_pop, n_begin);
		$display("%0d quads checked, %0d still pending",
			board.matched, board.pending.size());
		if (board.errors == 0 && board.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
